// ===== design/cssort_pkg.sv =====
// ----------------------------------------------------------------------------
// cssort_pkg
// Shared types and the value width of the cocktail shaker sorter: input item and
// result item layouts.
// ----------------------------------------------------------------------------
package cssort_pkg;

	localparam int VALUE_BITS = 32;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         is_last;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] sorted_value;
		logic                         end_of_set;
		logic                         dropped;
	} result_t;

endpackage

// ===== design/cssort_ram.sv =====
// ----------------------------------------------------------------------------
// cssort_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cssort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/cssort_cx.sv =====
// ----------------------------------------------------------------------------
// cssort_cx
// Compare-exchange unit. Holds the carried element of a pass against the next
// neighbor: a forward pass carries the largest seen, a backward pass the
// smallest. Returns the element to write back behind the carry.
// ----------------------------------------------------------------------------
module cssort_cx #(
	parameter int WIDTH = 32
) (
	input  logic [WIDTH-1:0] carry,
	input  logic [WIDTH-1:0] elem,
	input  logic             fwd,
	output logic             swap,
	output logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] next_carry
);

	always_comb begin
		// strict signed compare: equal elements never move
		if (fwd) begin
			swap = $signed(carry) > $signed(elem);
		end else begin
			swap = $signed(elem) > $signed(carry);
		end
		if (swap) begin
			wr_data    = elem;
			next_carry = carry;
		end else begin
			wr_data    = carry;
			next_carry = elem;
		end
	end

endmodule

// ===== design/cocktail_shaker_sorter_core.sv =====
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_core
// Loads a set of signed elements, sorts it ascending with alternating bubble
// passes whose bounds shrink to the last swap, then emits it in order.
//
//  channel | ports                 | transfer
//  --------+-----------------------+-----------------------------------
//  input   | start, busy, item     | edge with start high and busy low
//  result  | result_valid, result  | every cycle result_valid is high
//
//  Loading accepts one element per input transfer. After the closing element
//  the sort runs on one compare-exchange unit over the element RAM, which has
//  one write and one read port; each compare reads the next element, then
//  writes one back. Emission streams one result per cycle.
//  busy is high from the closing transfer until the last result; the
//  receiver cannot stall. Reset clears the control state; the element RAM
//  needs no clearing since only entries of the current set are read.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter_core #(
	parameter int MAX_ITEMS    = 32,
	parameter int ELEMENT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cssort_pkg::item_t   item,
	output logic                result_valid,
	output cssort_pkg::result_t result
);

	localparam int VAL_W  = cssort_pkg::VALUE_BITS;
	localparam int ELEM_W = (ELEMENT_BITS < VAL_W) ? ELEMENT_BITS : VAL_W;
	localparam int IDX_W  = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_START,
		S_FIRST,
		S_RD,
		S_CMP,
		S_END,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  low_q;
	logic [IDX_W-1:0]  high_q;
	logic [IDX_W-1:0]  p_q;
	logic [IDX_W-1:0]  last_q;
	logic [IDX_W-1:0]  emit_q;
	logic              fwd_q;
	logic              swapped_q;
	logic              ovf_q;
	logic [ELEM_W-1:0] carry_q;
	logic              valid_s1;
	logic              end_s1;
	logic              drop_s1;

	logic              accept;
	logic              full;
	logic [IDX_W-1:0]  n_last;
	logic [IDX_W-1:0]  p_next;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [ELEM_W-1:0] wdata;
	logic [IDX_W-1:0]  raddr;
	logic [ELEM_W-1:0] rdata;
	logic              cx_swap;
	logic [ELEM_W-1:0] cx_wr;
	logic [ELEM_W-1:0] cx_carry;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_ITEMS));
	assign n_last = IDX_W'(count_q - CNT_W'(1));
	assign p_next = fwd_q ? (p_q + IDX_W'(1)) : (p_q - IDX_W'(1));

	cssort_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	cssort_cx #(
		.WIDTH(ELEM_W)
	) u_cx (
		.carry     (carry_q),
		.elem      (rdata),
		.fwd       (fwd_q),
		.swap      (cx_swap),
		.wr_data   (cx_wr),
		.next_carry(cx_carry)
	);

	// RAM port control
	always_comb begin
		we    = 1'b0;
		waddr = IDX_W'(count_q);
		wdata = item.value[ELEM_W-1:0];
		raddr = p_q;
		unique case (state_q)
			S_IDLE: begin
				we = accept && !full;
			end
			S_START: begin
				raddr = fwd_q ? low_q : high_q;
			end
			S_RD: begin
				raddr = p_next;
			end
			S_CMP: begin
				we    = 1'b1;
				waddr = p_q;
				wdata = cx_wr;
			end
			S_END: begin
				we    = 1'b1;
				waddr = p_q;
				wdata = carry_q;
			end
			S_EMIT: begin
				raddr = emit_q;
			end
			S_INIT, S_FIRST: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			low_q     <= '0;
			high_q    <= '0;
			p_q       <= '0;
			last_q    <= '0;
			emit_q    <= '0;
			fwd_q     <= 1'b1;
			swapped_q <= 1'b0;
			ovf_q     <= 1'b0;
			carry_q   <= '0;
			valid_s1  <= 1'b0;
			end_s1    <= 1'b0;
			drop_s1   <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_EMIT);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (item.is_last) begin
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					emit_q <= '0;
					if (count_q < CNT_W'(2)) begin
						state_q <= S_EMIT;
					end else begin
						low_q   <= '0;
						high_q  <= n_last;
						fwd_q   <= 1'b1;
						state_q <= S_START;
					end
				end
				S_START: begin
					// empty pass: nothing left to sort
					if (low_q >= high_q) begin
						emit_q  <= '0;
						state_q <= S_EMIT;
					end else begin
						p_q       <= fwd_q ? low_q : high_q;
						swapped_q <= 1'b0;
						last_q    <= '0;
						state_q   <= S_FIRST;
					end
				end
				S_FIRST: begin
					carry_q <= rdata;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					carry_q <= cx_carry;
					if (cx_swap) begin
						swapped_q <= 1'b1;
						last_q    <= p_q;
					end
					p_q <= p_next;
					if (p_next == (fwd_q ? high_q : low_q)) begin
						state_q <= S_END;
					end else begin
						state_q <= S_RD;
					end
				end
				S_END: begin
					fwd_q <= !fwd_q;
					if (swapped_q) begin
						if (fwd_q) begin
							high_q <= last_q;
						end else begin
							low_q <= last_q;
						end
						state_q <= S_START;
					end else begin
						emit_q  <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					end_s1  <= (emit_q == n_last);
					drop_s1 <= ovf_q;
					if (emit_q == n_last) begin
						// close the set; last result leaves next cycle from the RAM register
						count_q <= '0;
						ovf_q   <= 1'b0;
						low_q   <= '0;
						high_q  <= '0;
						fwd_q   <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						emit_q <= emit_q + IDX_W'(1);
					end
				end
			endcase
		end
	end

	assign result_valid = valid_s1;

	always_comb begin
		result.sorted_value = VAL_W'($signed(rdata));
		result.end_of_set   = end_s1;
		result.dropped      = drop_s1;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("element count beyond capacity");

	a_step_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (fwd_q ? (p_q < high_q) : (p_q > low_q)))
		else $error("compare position outside pass bounds");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == S_EMIT))
		else $error("result without emission step");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.end_of_set) |=> !result_valid)
		else $error("result after end of set");

endmodule
